### hw/rtl/evr_pkg.sv
// ----------------------------------------------------------------------------
// evr_pkg
// shared types, constants and the cordic arctangent table for the rotation block
// ----------------------------------------------------------------------------
package evr_pkg;

   localparam int COORD_WIDTH       = 32;
   localparam int ANGLE_WIDTH_DEF   = 16;
   localparam int FRAC              = 24;
   localparam int COEF_W            = 27;
   localparam int CV_W              = 34;
   localparam int CORDIC_STEPS      = 30;
   localparam int STEP_W            = $clog2(CORDIC_STEPS + 1);
   localparam int CORDIC_GAIN       = 652032874;
   localparam int N_PROD            = 14;
   localparam int PROD_IDX_W        = $clog2(N_PROD + 1);
   localparam int CSR_INDEX_W       = 2;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_ANGLE_X = 2'd0,
      REG_ANGLE_Y = 2'd1,
      REG_ANGLE_Z = 2'd2
   } reg_index_type;

   typedef logic signed [COORD_WIDTH-1:0] coord_type;
   typedef logic signed [COEF_W-1:0]      coef_type;

   typedef struct packed {
      coord_type in_x;
      coord_type in_y;
      coord_type in_z;
   } req_type;

   typedef struct packed {
      coord_type out_x;
      coord_type out_y;
      coord_type out_z;
   } rsp_type;

   // row-major coefficients, entry 3*i+j is row i column j
   typedef struct packed {
      coef_type [8:0] m;
   } matrix_type;

   function automatic logic [31:0] atan_at(input logic [STEP_W-1:0] i);
      logic [31:0] r;
      case (i)
         5'd0:    r = 32'd536870912;
         5'd1:    r = 32'd316933406;
         5'd2:    r = 32'd167458907;
         5'd3:    r = 32'd85004756;
         5'd4:    r = 32'd42667331;
         5'd5:    r = 32'd21354465;
         5'd6:    r = 32'd10679838;
         5'd7:    r = 32'd5340245;
         5'd8:    r = 32'd2670163;
         5'd9:    r = 32'd1335087;
         5'd10:   r = 32'd667544;
         5'd11:   r = 32'd333772;
         5'd12:   r = 32'd166886;
         5'd13:   r = 32'd83443;
         5'd14:   r = 32'd41722;
         5'd15:   r = 32'd20861;
         5'd16:   r = 32'd10430;
         5'd17:   r = 32'd5215;
         5'd18:   r = 32'd2608;
         5'd19:   r = 32'd1304;
         5'd20:   r = 32'd652;
         5'd21:   r = 32'd326;
         5'd22:   r = 32'd163;
         5'd23:   r = 32'd81;
         5'd24:   r = 32'd41;
         5'd25:   r = 32'd20;
         5'd26:   r = 32'd10;
         5'd27:   r = 32'd5;
         5'd28:   r = 32'd3;
         5'd29:   r = 32'd1;
         default: r = 32'd0;
      endcase
      return r;
   endfunction

endpackage

### hw/rtl/evr_cordic.sv
// ----------------------------------------------------------------------------
// evr_cordic
// iterative rotation-mode cordic, one step per cycle, sine and cosine in q24
// ----------------------------------------------------------------------------
module evr_cordic
   import evr_pkg::*;
#(
   parameter int ANGLE_WIDTH = ANGLE_WIDTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [ANGLE_WIDTH-1:0] angle,
   output logic                   done,
   output coef_type               sin_q,
   output coef_type               cos_q
);

   logic [31:0]             phase;
   logic                    neg_in;
   logic [31:0]             phase_adj;
   logic signed [CV_W-1:0]  x_ff, y_ff, z_ff;
   logic signed [CV_W-1:0]  x_in, y_in, z_in;
   logic signed [CV_W-1:0]  dx, dy, at;
   logic [STEP_W-1:0]       step_ff, step_in;
   logic                    run_ff, run_in;
   logic                    done_ff, done_in;
   logic                    neg_ff, neg_in2;
   logic signed [CV_W-1:0]  xn, yn, xr, yr;

   localparam logic signed [CV_W-1:0] ONE  = CV_W'(1) <<< FRAC;
   localparam logic signed [CV_W-1:0] MONE = -ONE;
   localparam logic signed [CV_W-1:0] HALF = CV_W'(32);

   assign phase     = {angle, {(32 - ANGLE_WIDTH){1'b0}}};
   assign neg_in    = (phase[31:30] == 2'b01) || (phase[31:30] == 2'b10);
   assign phase_adj = neg_in ? (phase + 32'h8000_0000) : phase;

   assign dx = y_ff >>> step_ff;
   assign dy = x_ff >>> step_ff;
   assign at = $signed({{(CV_W - 32){1'b0}}, atan_at(step_ff)});

   always_comb begin
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      step_in = step_ff;
      run_in  = run_ff;
      neg_in2 = neg_ff;
      done_in = 1'b0;
      if (start) begin
         x_in    = CV_W'(CORDIC_GAIN);
         y_in    = '0;
         z_in    = CV_W'($signed(phase_adj));
         step_in = '0;
         run_in  = 1'b1;
         neg_in2 = neg_in;
      end else if (run_ff) begin
         if (!z_ff[CV_W-1]) begin
            x_in = x_ff - dx;
            y_in = y_ff + dy;
            z_in = z_ff - at;
         end else begin
            x_in = x_ff + dx;
            y_in = y_ff - dy;
            z_in = z_ff + at;
         end
         step_in = step_ff + STEP_W'(1);
         if (step_ff == STEP_W'(CORDIC_STEPS - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      x_ff   <= x_in;
      y_ff   <= y_in;
      z_ff   <= z_in;
      neg_ff <= neg_in2;
   end

   assign xn = neg_ff ? -x_ff : x_ff;
   assign yn = neg_ff ? -y_ff : y_ff;
   assign xr = (xn + HALF) >>> (30 - FRAC);
   assign yr = (yn + HALF) >>> (30 - FRAC);

   assign cos_q = (xr > ONE) ? COEF_W'(ONE) : (xr < MONE) ? COEF_W'(MONE) : COEF_W'(xr);
   assign sin_q = (yr > ONE) ? COEF_W'(ONE) : (yr < MONE) ? COEF_W'(MONE) : COEF_W'(yr);
   assign done  = done_ff;

endmodule

### hw/rtl/evr_matrix.sv
// ----------------------------------------------------------------------------
// evr_matrix
// angle registers and the sequencer that rebuilds the rotation matrix
// ----------------------------------------------------------------------------
module evr_matrix
   import evr_pkg::*;
#(
   parameter int ANGLE_WIDTH = ANGLE_WIDTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [ANGLE_WIDTH-1:0] csr_wdata,
   output logic                   busy,
   output matrix_type             matrix
);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_CORDIC = 4'b0010,
      ST_MUL    = 4'b0100,
      ST_COMB   = 4'b1000
   } state_type;

   state_type                state_ff, state_in;
   logic [ANGLE_WIDTH-1:0]   ang_ff [3];
   logic                     pending_ff, pending_in;
   logic                     wr;
   logic                     cstart;
   logic [2:0]               cdone;
   coef_type                 csin [3];
   coef_type                 ccos [3];
   coef_type                 s_ff [3];
   coef_type                 c_ff [3];
   logic [PROD_IDX_W-1:0]    k_ff, k_in;
   logic                     issue;
   coef_type                 op_a, op_b;
   logic signed [2*COEF_W-1:0] prod_ff, rnd;
   logic                     mv_ff;
   logic [PROD_IDX_W-1:0]    midx_ff;
   coef_type                 pr_ff [N_PROD];
   matrix_type               mat_ff;

   assign csr_ready = 1'b1;
   assign wr        = csr_valid && csr_ready;
   assign cstart    = (state_ff == ST_IDLE) && pending_ff;
   assign issue     = (state_ff == ST_MUL) && (k_ff < PROD_IDX_W'(N_PROD));

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) ang_ff[i] <= '0;
      end else if (wr) begin
         unique case (csr_index)
            REG_ANGLE_X: ang_ff[0] <= csr_wdata;
            REG_ANGLE_Y: ang_ff[1] <= csr_wdata;
            REG_ANGLE_Z: ang_ff[2] <= csr_wdata;
            default: ;
         endcase
      end
   end

   for (genvar g = 0; g < 3; g++) begin : g_cordic
      evr_cordic #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_cordic (
         .clock (clock),
         .reset (reset),
         .start (cstart),
         .angle (ang_ff[g]),
         .done  (cdone[g]),
         .sin_q (csin[g]),
         .cos_q (ccos[g])
      );
   end

   always_comb begin
      state_in   = state_ff;
      pending_in = pending_ff;
      k_in       = k_ff;
      if (cstart) pending_in = 1'b0;
      if (wr) pending_in = 1'b1;
      unique case (state_ff)
         ST_IDLE:   if (pending_ff) state_in = ST_CORDIC;
         ST_CORDIC: begin
            if (&cdone) begin
               state_in = ST_MUL;
               k_in     = '0;
            end
         end
         ST_MUL: begin
            if (issue) k_in = k_ff + PROD_IDX_W'(1);
            else state_in = ST_COMB;
         end
         ST_COMB:   state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         pending_ff <= 1'b1;
         k_ff       <= '0;
         mv_ff      <= 1'b0;
      end else begin
         state_ff   <= state_in;
         pending_ff <= pending_in;
         k_ff       <= k_in;
         mv_ff      <= issue;
      end
   end

   // s/c index 0 is x (a), 1 is y (b), 2 is z (g)
   always_comb begin
      case (k_ff)
         4'd0:    begin op_a = s_ff[0];  op_b = s_ff[1]; end
         4'd1:    begin op_a = c_ff[0];  op_b = s_ff[1]; end
         4'd2:    begin op_a = c_ff[1];  op_b = c_ff[2]; end
         4'd3:    begin op_a = c_ff[1];  op_b = s_ff[2]; end
         4'd4:    begin op_a = pr_ff[0]; op_b = c_ff[2]; end
         4'd5:    begin op_a = c_ff[0];  op_b = s_ff[2]; end
         4'd6:    begin op_a = pr_ff[0]; op_b = s_ff[2]; end
         4'd7:    begin op_a = c_ff[0];  op_b = c_ff[2]; end
         4'd8:    begin op_a = s_ff[0];  op_b = c_ff[1]; end
         4'd9:    begin op_a = pr_ff[1]; op_b = c_ff[2]; end
         4'd10:   begin op_a = s_ff[0];  op_b = s_ff[2]; end
         4'd11:   begin op_a = pr_ff[1]; op_b = s_ff[2]; end
         4'd12:   begin op_a = s_ff[0];  op_b = c_ff[2]; end
         4'd13:   begin op_a = c_ff[0];  op_b = c_ff[1]; end
         default: begin op_a = '0;       op_b = '0;      end
      endcase
   end

   assign rnd = prod_ff + ((2*COEF_W)'(1) <<< (FRAC - 1));

   always_ff @(posedge clock) begin
      if (state_ff == ST_CORDIC && (&cdone)) begin
         for (int i = 0; i < 3; i++) begin
            s_ff[i] <= csin[i];
            c_ff[i] <= ccos[i];
         end
      end
      prod_ff <= op_a * op_b;
      midx_ff <= k_ff;
      if (mv_ff) pr_ff[midx_ff[PROD_IDX_W-1:0]] <= rnd[FRAC+COEF_W-1:FRAC];
      if (state_ff == ST_COMB) begin
         mat_ff.m[0] <= pr_ff[2];
         mat_ff.m[1] <= -pr_ff[3];
         mat_ff.m[2] <= s_ff[1];
         mat_ff.m[3] <= pr_ff[4] + pr_ff[5];
         mat_ff.m[4] <= pr_ff[7] - pr_ff[6];
         mat_ff.m[5] <= -pr_ff[8];
         mat_ff.m[6] <= pr_ff[10] - pr_ff[9];
         mat_ff.m[7] <= pr_ff[11] + pr_ff[12];
         mat_ff.m[8] <= pr_ff[13];
      end
   end

   assign busy   = pending_ff || (state_ff != ST_IDLE);
   assign matrix = mat_ff;

   a_wr_busy: assert property (@(posedge clock) disable iff (reset) wr |=> busy)
      else $error("csr write did not raise busy");
   a_done_state: assert property (@(posedge clock) disable iff (reset)
      cdone[0] |-> state_ff == ST_CORDIC)
      else $error("cordic finished outside its phase");
   a_drain: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MUL && !issue) |=> state_ff == ST_COMB && !mv_ff)
      else $error("product drain out of order");

endmodule

### hw/rtl/evr_datapath.sv
// ----------------------------------------------------------------------------
// evr_datapath
// four-stage vector times matrix pipeline with rounding and saturation
// ----------------------------------------------------------------------------
module evr_datapath
   import evr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   input  req_type    req,
   input  matrix_type matrix,
   output logic       out_valid,
   output rsp_type    rsp
);

   localparam int VH_W = COORD_WIDTH - 16;
   localparam int HP_W = COEF_W + VH_W;
   localparam int LP_W = COEF_W + 17;
   localparam int HS_W = HP_W + 2;
   localparam int LS_W = LP_W + 2;
   localparam int T_W  = HS_W + 1;
   localparam int R_W  = T_W - (FRAC - 16);

   logic [3:0]              v_ff;
   logic signed [VH_W-1:0]  vh_ff [3];
   logic [15:0]             vl_ff [3];
   logic signed [HP_W-1:0]  hp_ff [9];
   logic signed [LP_W-1:0]  lp_ff [9];
   logic signed [HS_W-1:0]  hs_ff [3];
   logic signed [LS_W-1:0]  ls_ff [3];
   coord_type               out_ff [3];
   coord_type               vin [3];
   coord_type               sat [3];
   logic signed [T_W-1:0]   t [3];
   logic signed [R_W-1:0]   r [3];

   localparam coord_type CMAX = {1'b0, {(COORD_WIDTH - 1){1'b1}}};
   localparam coord_type CMIN = {1'b1, {(COORD_WIDTH - 1){1'b0}}};

   assign vin[0] = req.in_x;
   assign vin[1] = req.in_y;
   assign vin[2] = req.in_z;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         t[i] = T_W'(hs_ff[i]) + T_W'(ls_ff[i] >>> 16);
         r[i] = t[i][T_W-1:FRAC-16];
         if ((&r[i][R_W-1:COORD_WIDTH-1]) || !(|r[i][R_W-1:COORD_WIDTH-1]))
            sat[i] = r[i][COORD_WIDTH-1:0];
         else if (r[i][R_W-1])
            sat[i] = CMIN;
         else
            sat[i] = CMAX;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) v_ff <= '0;
      else v_ff <= {v_ff[2:0], in_valid};
      for (int j = 0; j < 3; j++) begin
         vh_ff[j] <= vin[j][COORD_WIDTH-1:16];
         vl_ff[j] <= vin[j][15:0];
      end
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            hp_ff[3*i+j] <= matrix.m[3*i+j] * vh_ff[j];
            lp_ff[3*i+j] <= matrix.m[3*i+j] * $signed({1'b0, vl_ff[j]});
         end
         hs_ff[i] <= HS_W'(hp_ff[3*i]) + HS_W'(hp_ff[3*i+1]) + HS_W'(hp_ff[3*i+2]);
         ls_ff[i] <= LS_W'(lp_ff[3*i]) + LS_W'(lp_ff[3*i+1]) + LS_W'(lp_ff[3*i+2])
                     + (LS_W'(1) <<< (FRAC - 1));
         out_ff[i] <= sat[i];
      end
   end

   assign out_valid = v_ff[3];
   assign rsp.out_x = out_ff[0];
   assign rsp.out_y = out_ff[1];
   assign rsp.out_z = out_ff[2];

endmodule

### hw/rtl/euler_xyz_vector_rotation.sv
// ----------------------------------------------------------------------------
// euler_xyz_vector_rotation
// rotates q16.16 vectors by the configured x, y and z euler angles
// ----------------------------------------------------------------------------
// A vector beat is taken whenever start is high and busy is low, one per cycle,
// and its rotated result passes the input, product, sum and output registers
// and shows on rsp_data for a single cycle, flagged by rsp_valid; the receiver
// cannot stall, so it must take every beat as it comes. After reset and after
// every angle write the block rebuilds its matrix with three cordic units and
// one shared multiplier, holding busy high until the new matrix is in place.
module euler_xyz_vector_rotation
   import evr_pkg::*;
#(
   parameter int ANGLE_WIDTH = ANGLE_WIDTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  req_type                req_data,
   output logic                   rsp_valid,
   output rsp_type                rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [ANGLE_WIDTH-1:0] csr_wdata
);

   matrix_type matrix;
   logic       accept;

   assign accept = start && !busy;

   evr_matrix #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_matrix (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .busy      (busy),
      .matrix    (matrix)
   );

   evr_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .req       (req_data),
      .matrix    (matrix),
      .out_valid (rsp_valid),
      .rsp       (rsp_data)
   );

endmodule
